>>> sv/leaper_grid_shortest_path_core_assert.svh
// assertion macros shared by the rtl
`ifndef LEAPER_GRID_SHORTEST_PATH_CORE_ASSERT_SVH
`define LEAPER_GRID_SHORTEST_PATH_CORE_ASSERT_SVH

// same-cycle implication
`define LGSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LGSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lgsp_pkg.sv
`default_nettype none

package lgsp_pkg;

    localparam int MAX_SIDE_DEF = 32;
    localparam int STEP_W       = 5;
    localparam int CFG_W        = 6;
    localparam int DIST_W       = 11;
    localparam int MOVES        = 8;
    localparam int MOVE_W       = $clog2(MOVES);
    localparam int DIST_MAX     = 1023;

    localparam logic [CFG_W-1:0]         SIDE_RESET = CFG_W'(8);
    localparam logic signed [DIST_W-1:0] DIST_NONE  = -DIST_W'(1);
    localparam logic [MOVE_W-1:0]        MOVE_LAST  = MOVE_W'(MOVES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_POP,
        S_LOAD,
        S_CHECK,
        S_TEST,
        S_DONE
    } search_state_t;

    // top level to search sequencer
    typedef struct packed {
        logic start;
        logic result_free;
    } search_ctrl_t;

    // search sequencer to top level
    typedef struct packed {
        logic idle;
        logic done;
    } search_status_t;

endpackage

`default_nettype wire

>>> sv/lgsp_request_if.sv
`default_nettype none

interface lgsp_request_if;
    import lgsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_b;

    modport source (output valid, output step_a, output step_b, input ready);
    modport sink (input valid, input step_a, input step_b, output ready);
endinterface

`default_nettype wire

>>> sv/lgsp_response_if.sv
`default_nettype none

interface lgsp_response_if;
    import lgsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

`default_nettype wire

>>> sv/lgsp_cfg_if.sv
`default_nettype none

interface lgsp_cfg_if;
    import lgsp_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] board_side;

    modport source (output valid, output board_side, input ready);
    modport sink (input valid, input board_side, output ready);
endinterface

`default_nettype wire

>>> sv/lgsp_move_unit.sv
`default_nettype none

module lgsp_move_unit #(
    parameter int MAX_SIDE = lgsp_pkg::MAX_SIDE_DEF
) (
    input  wire logic [$clog2(MAX_SIDE)-1:0]   x,
    input  wire logic [$clog2(MAX_SIDE)-1:0]   y,
    input  wire logic [lgsp_pkg::STEP_W-1:0]   step_a,
    input  wire logic [lgsp_pkg::STEP_W-1:0]   step_b,
    input  wire logic [lgsp_pkg::MOVE_W-1:0]   move,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0] side,
    output logic [$clog2(MAX_SIDE)-1:0]        nx,
    output logic [$clog2(MAX_SIDE)-1:0]        ny,
    output logic                               on_board
);
    import lgsp_pkg::*;

    localparam int XW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = SW + STEP_W + 2;

    logic [STEP_W-1:0]   mag_x;
    logic [STEP_W-1:0]   mag_y;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] lim;

    // move bit 2 swaps the steps, bit 1 negates x, bit 0 negates y
    always_comb
    begin
        mag_x    = move[2] ? step_b : step_a;
        mag_y    = move[2] ? step_a : step_b;
        px       = signed'(CW'(x));
        py       = signed'(CW'(y));
        lim      = signed'(CW'(side));
        qx       = move[1] ? (px - signed'(CW'(mag_x))) : (px + signed'(CW'(mag_x)));
        qy       = move[0] ? (py - signed'(CW'(mag_y))) : (py + signed'(CW'(mag_y)));
        on_board = (qx >= 0) && (qx < lim) && (qy >= 0) && (qy < lim);
        nx       = qx[XW-1:0];
        ny       = qy[XW-1:0];
    end
endmodule

`default_nettype wire

>>> sv/lgsp_search.sv
`default_nettype none

module lgsp_search #(
    parameter int MAX_SIDE = lgsp_pkg::MAX_SIDE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lgsp_pkg::search_ctrl_t             ctrl,
    input  wire logic [lgsp_pkg::STEP_W-1:0]        step_a,
    input  wire logic [lgsp_pkg::STEP_W-1:0]        step_b,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]      side,
    output lgsp_pkg::search_status_t                status,
    output logic signed [lgsp_pkg::DIST_W-1:0]      distance
);
    import lgsp_pkg::*;

    localparam int XW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = 2 * XW;
    localparam int VDEP  = 1 << AW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int QIW   = $clog2(CELLS);
    localparam int QW    = $clog2(CELLS + 1);
    localparam int DW    = QIW;
    localparam int QEW   = AW + DW;

    search_state_t state_reg, state_next;

    logic [AW-1:0]     clr_reg, clr_next;
    logic [QW-1:0]     head_reg, head_next;
    logic [QW-1:0]     tail_reg, tail_next;
    logic [XW-1:0]     cx_reg, cx_next;
    logic [XW-1:0]     cy_reg, cy_next;
    logic [DW-1:0]     cd_reg, cd_next;
    logic [MOVE_W-1:0] move_reg, move_next;
    logic [STEP_W-1:0] a_reg, a_next;
    logic [STEP_W-1:0] b_reg, b_next;
    logic [SW-1:0]     side_reg, side_next;
    logic [AW-1:0]     naddr_reg, naddr_next;
    logic              found_reg, found_next;
    logic [DW-1:0]     fdist_reg, fdist_next;

    // visited map and frontier queue
    logic           vis_mem [VDEP];
    logic           vis_rd_reg;
    logic           vis_we;
    logic [AW-1:0]  vis_waddr;
    logic           vis_wdata;
    logic [AW-1:0]  vis_raddr;

    logic [QEW-1:0] q_mem [CELLS];
    logic [QEW-1:0] q_rd_reg;
    logic           q_we;
    logic [QIW-1:0] q_waddr;
    logic [QEW-1:0] q_wdata;
    logic [QIW-1:0] q_raddr;

    logic [XW-1:0] nx;
    logic [XW-1:0] ny;
    logic          on_board;
    logic [XW-1:0] last;
    logic [DW-1:0] cd_inc;

    lgsp_move_unit #(
        .MAX_SIDE (MAX_SIDE)
    ) u_move (
        .x        (cx_reg),
        .y        (cy_reg),
        .step_a   (a_reg),
        .step_b   (b_reg),
        .move     (move_reg),
        .side     (side_reg),
        .nx       (nx),
        .ny       (ny),
        .on_board (on_board)
    );

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[vis_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    always_comb
    begin
        last   = XW'(side_reg - SW'(1));
        cd_inc = cd_reg + DW'(1);

        state_next = state_reg;
        clr_next   = clr_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cd_next    = cd_reg;
        move_next  = move_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        side_next  = side_reg;
        naddr_next = naddr_reg;
        found_next = found_reg;
        fdist_next = fdist_reg;

        vis_we    = 1'b0;
        vis_waddr = clr_reg;
        vis_wdata = 1'b0;
        vis_raddr = {ny, nx};
        q_we      = 1'b0;
        q_waddr   = tail_reg[QIW-1:0];
        q_wdata   = {naddr_reg, cd_inc};
        q_raddr   = head_reg[QIW-1:0];

        status.idle = 1'b0;
        status.done = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                status.idle = 1'b1;
                if (ctrl.start)
                begin
                    a_next     = step_a;
                    b_next     = step_b;
                    side_next  = side;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                vis_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                // seed the corner cell at distance zero
                vis_we     = 1'b1;
                vis_waddr  = '0;
                vis_wdata  = 1'b1;
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = '0;
                head_next  = '0;
                tail_next  = QW'(1);
                found_next = (side_reg == SW'(1));
                fdist_next = '0;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + QW'(1);
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOAD:
            begin
                {cy_next, cx_next, cd_next} = q_rd_reg;
                move_next  = '0;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                naddr_next = {ny, nx};
                if (on_board)
                begin
                    state_next = S_TEST;
                end
                else if (move_reg == MOVE_LAST)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    move_next = move_reg + MOVE_W'(1);
                end
            end
            S_TEST:
            begin
                if (!vis_rd_reg)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = naddr_reg;
                    vis_wdata = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + QW'(1);
                    if (naddr_reg == {last, last})
                    begin
                        found_next = 1'b1;
                        fdist_next = cd_inc;
                    end
                end
                if (move_reg == MOVE_LAST)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    move_next  = move_reg + MOVE_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (ctrl.result_free)
                begin
                    status.done = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (!found_reg)
        begin
            distance = DIST_NONE;
        end
        else if (32'(fdist_reg) > 32'(DIST_MAX))
        begin
            distance = DIST_W'(DIST_MAX);
        end
        else
        begin
            distance = signed'(DIST_W'(fdist_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            clr_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            move_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            move_reg  <= move_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cd_reg    <= cd_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        side_reg  <= side_next;
        naddr_reg <= naddr_next;
        fdist_reg <= fdist_next;
    end
endmodule

`default_nettype wire

>>> sv/leaper_grid_shortest_path_core.sv
// channel   | role   | payload                  | meaning
// ----------+--------+--------------------------+---------------------------------------
// request   | sink   | step_a[4:0], step_b[4:0] | leaper step sizes, one search each
// response  | source | distance[10:0] signed    | fewest moves to far corner, -1 if none
// cfg       | sink   | board_side[5:0]          | board side, 0 acts as 1, saturates high
//
// per item: the visited map is cleared one entry at a time, then the corner cell is seeded;
// each dequeued cell is popped and loaded, then its moves go one at a time through the
// shared move unit, each on-board neighbor taking one more step for its visited lookup
// the visited map has one read and one write port; the sequencer steps set the pace
// reset: rst_n asynchronous active low; board side returns to 8, block idle, no result
// request.ready is high only while idle; a finished result waits in the output
// register and the search holds in its done state until that register frees up

`default_nettype none

`include "leaper_grid_shortest_path_core_assert.svh"

module leaper_grid_shortest_path_core #(
    parameter int MAX_SIDE = lgsp_pkg::MAX_SIDE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lgsp_request_if.sink     request,
    lgsp_response_if.source  response,
    lgsp_cfg_if.sink         cfg
);
    import lgsp_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);

    // board side register, always writable
    logic [CFG_W-1:0] side_cfg_reg, side_cfg_next;
    logic [CFG_W:0]   side_wide;
    logic [SW-1:0]    side_sat;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DIST_W-1:0] out_dist_reg, out_dist_next;

    search_ctrl_t             search_ctrl;
    search_status_t           search_status;
    logic signed [DIST_W-1:0] search_dist;

    logic req_xfer;
    logic resp_xfer;

    assign cfg.ready         = 1'b1;
    assign request.ready     = search_status.idle;
    assign response.valid    = out_valid_reg;
    assign response.distance = out_dist_reg;

    assign req_xfer  = request.valid && request.ready;
    assign resp_xfer = out_valid_reg && response.ready;

    always_comb
    begin
        // a side of zero behaves as one, anything above the storage saturates
        side_wide = {1'b0, side_cfg_reg};
        if (side_wide == '0)
        begin
            side_sat = SW'(1);
        end
        else if (32'(side_wide) > 32'(MAX_SIDE))
        begin
            side_sat = SW'(MAX_SIDE);
        end
        else
        begin
            side_sat = SW'(side_wide);
        end

        side_cfg_next = side_cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            side_cfg_next = cfg.board_side;
        end

        search_ctrl.start       = req_xfer;
        // the search may hand over its result when the output register is free
        search_ctrl.result_free = !out_valid_reg || response.ready;

        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        if (search_status.done)
        begin
            out_valid_next = 1'b1;
            out_dist_next  = search_dist;
        end
        else if (resp_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    lgsp_search #(
        .MAX_SIDE (MAX_SIDE)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (search_ctrl),
        .step_a   (request.step_a),
        .step_b   (request.step_b),
        .side     (side_sat),
        .status   (search_status),
        .distance (search_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg  <= SIDE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            side_cfg_reg  <= side_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg <= out_dist_next;
    end

    // a transfer in starts a search, so the block is busy right after
    `LGSP_ASSERT_NXT(a_busy_after_start, clk, rst_n, req_xfer, !request.ready, "ready after start")

    // a result is only handed over when the output register can take it
    `LGSP_ASSERT_IMP(a_no_overwrite, clk, rst_n, search_status.done, search_ctrl.result_free, "result lost")

    // a new result shows up only after the search finished
    `LGSP_ASSERT_IMP(a_valid_from_done, clk, rst_n, $rose(out_valid_reg), $past(search_status.done), "spurious result")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lgsp_pkg::*;

    // board cells at the largest side the block supports
    localparam int CELL_COUNT  = MAX_SIDE_DEF * MAX_SIDE_DEF;
    // about 100 searches, some on the full board, plus stalls, stay far below this
    // limit, so this only trips on a hang
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int REPORT_MAX  = 10;

    // one search as issued, with the distance the board model predicts for it
    typedef struct {
        logic [STEP_W-1:0]        step_a;
        logic [STEP_W-1:0]        step_b;
        logic [CFG_W-1:0]         side;
        logic signed [DIST_W-1:0] distance;
    } leap_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lgsp_request_if  req_ch ();
    lgsp_response_if rsp_ch ();
    lgsp_cfg_if      cfg_ch ();

    leaper_grid_shortest_path_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch),
        .cfg      (cfg_ch)
    );

    // searches accepted by the block whose distance has not come back yet
    leap_result_t pending_paths[$];

    // board side as last written, raw 6-bit value (0 and >32 are clamped by the model)
    logic [CFG_W-1:0] side_shadow = SIDE_RESET;

    // when clear, neither channel inserts idle cycles
    bit idle_gaps = 1'b1;

    int searches_sent;
    int distances_checked;
    int side_writes;
    int failures;
    int cycle_count;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d searches still pending",
                     cycle_count, pending_paths.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // breadth-first search from corner (0,0) to the far corner with leaper steps (a,b)
    function automatic logic signed [DIST_W-1:0] leaper_distance(
        input logic [CFG_W-1:0]  side_reg,
        input logic [STEP_W-1:0] a,
        input logic [STEP_W-1:0] b
    );
        int side;
        int ia;
        int ib;
        int dx[MOVES];
        int dy[MOVES];
        bit seen[CELL_COUNT];
        int hops[CELL_COUNT];
        int frontier[CELL_COUNT];
        int head;
        int tail;
        int spot;
        int x;
        int y;
        int nx;
        int ny;
        int nc;
        int target;

        // zero acts as one, anything past the largest board saturates
        side = int'(side_reg);
        if (side < 1)
            side = 1;
        if (side > MAX_SIDE_DEF)
            side = MAX_SIDE_DEF;

        ia = int'(a);
        ib = int'(b);
        dx = '{ia, ia, -ia, -ia, ib, ib, -ib, -ib};
        dy = '{ib, -ib, ib, -ib, ia, -ia, ia, -ia};

        seen[0]     = 1'b1;
        hops[0]     = 0;
        frontier[0] = 0;
        head        = 0;
        tail        = 1;

        // each square enters the frontier once, so tail never passes the board size
        while (head < tail)
        begin
            spot = frontier[head];
            head++;
            x = spot % side;
            y = spot / side;
            for (int m = 0; m < MOVES; m++)
            begin
                nx = x + dx[m];
                ny = y + dy[m];
                if (nx >= 0 && nx < side && ny >= 0 && ny < side)
                begin
                    nc = ny * side + nx;
                    // a zero-length move lands on this square again, already seen
                    if (!seen[nc])
                    begin
                        seen[nc]       = 1'b1;
                        hops[nc]       = hops[spot] + 1;
                        frontier[tail] = nc;
                        tail++;
                    end
                end
            end
        end

        target = (side - 1) * side + (side - 1);
        if (!seen[target])
            return DIST_NONE;
        return DIST_W'((hops[target] > DIST_MAX) ? DIST_MAX : hops[target]);
    endfunction

    function automatic void report_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // request side: optional idle gap, then hold valid until the transfer
    // valid is left high on return so a back-to-back item never drops it for a step
    task automatic send_leap(input logic [STEP_W-1:0] a, input logic [STEP_W-1:0] b);
        int gap;
        leap_result_t entry;

        gap = idle_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.step_a <= a;
        req_ch.step_b <= b;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));

        // prediction taken with the side in force when the search was accepted
        entry.step_a   = a;
        entry.step_b   = b;
        entry.side     = side_shadow;
        entry.distance = leaper_distance(side_shadow, a, b);
        pending_paths.push_back(entry);
        searches_sent++;
        @(negedge clk);
    endtask

    // drop valid and wait until every accepted search has returned its distance,
    // then give the block time to fall back to idle
    task automatic drain_searches();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_paths.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // board side register write, only issued while the block is idle
    task automatic write_board_side(input logic [CFG_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.board_side <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        side_shadow = value;
        side_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // response side: per result either ready early, or hold ready low until valid
    // shows up and then stall before raising it; every transfer is checked in order
    initial
    begin : distance_sink
        int stall;
        leap_result_t want;

        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_gaps ? $urandom_range(0, 3) : 0;
            if (stall == 0)
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= 1'b0;
                do
                    @(posedge clk);
                while (!rsp_ch.valid);
                repeat (stall) @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));

            if (pending_paths.size() == 0)
                report_failure($sformatf("unexpected distance %0d with no search pending",
                                         rsp_ch.distance));
            else
            begin
                want = pending_paths.pop_front();
                distances_checked++;
                if (rsp_ch.distance !== want.distance)
                    report_failure($sformatf(
                        "mismatch: side %0d steps (%0d,%0d) expected %0d, got %0d",
                        want.side, want.step_a, want.step_b, want.distance,
                        rsp_ch.distance));
            end
            @(negedge clk);
        end
    end

    // reset value of the side (8): classic knight, zero and largest steps,
    // a single jump straight to the corner and a rook-like pair of moves
    task automatic test_reset_board();
        send_leap(5'd1, 5'd2);
        send_leap(5'd2, 5'd1);
        send_leap(5'd0, 5'd0);
        send_leap(5'd31, 5'd31);
        send_leap(5'd7, 5'd7);
        send_leap(5'd0, 5'd7);
        drain_searches();
    endtask

    // side zero behaves as one, side one starts on the target, sides above
    // the largest board saturate, and the full 32x32 board itself
    task automatic test_side_extremes();
        write_board_side(6'd0);
        send_leap(5'd1, 5'd2);
        send_leap(5'd0, 5'd0);
        drain_searches();

        write_board_side(6'd1);
        send_leap(5'd31, 5'd31);
        send_leap(5'd0, 5'd0);
        drain_searches();

        write_board_side(6'd63);
        send_leap(5'd1, 5'd2);
        send_leap(5'd31, 5'd31);
        drain_searches();

        // full board: both steps zero never leave the corner, long straight moves,
        // and a diagonal walk the whole length of the board
        write_board_side(6'd32);
        send_leap(5'd0, 5'd0);
        send_leap(5'd31, 5'd0);
        send_leap(5'd1, 5'd1);
        drain_searches();
    endtask

    // one step zero gives rook-like moves along a single axis
    task automatic test_zero_steps();
        write_board_side(6'd5);
        send_leap(5'd0, 5'd1);
        send_leap(5'd1, 5'd0);
        send_leap(5'd0, 5'd4);
        send_leap(5'd4, 5'd0);
        send_leap(5'd0, 5'd0);
        drain_searches();
    endtask

    // boards barely larger than one square, steps that overshoot them
    task automatic test_tiny_boards();
        write_board_side(6'd2);
        send_leap(5'd1, 5'd1);
        send_leap(5'd1, 5'd0);
        send_leap(5'd31, 5'd0);
        drain_searches();

        write_board_side(6'd3);
        send_leap(5'd1, 5'd2);
        drain_searches();
    endtask

    // random boards, mostly small so searches stay short; one phase on the full
    // board and one with an oversized side; most steps fit on the board, the
    // rest are arbitrary 5-bit values; some phases run without any idle cycles
    task automatic test_random_boards();
        int side_val;
        int count;
        logic [STEP_W-1:0] a;
        logic [STEP_W-1:0] b;

        for (int phase = 0; phase < 10; phase++)
        begin
            count = 9;
            if (phase == 3)
            begin
                side_val = MAX_SIDE_DEF;
                count    = 3;
            end
            else if (phase == 7)
            begin
                side_val = $urandom_range(MAX_SIDE_DEF + 1, 63);
                count    = 2;
            end
            else
                side_val = $urandom_range(2, 12);

            idle_gaps = (phase % 4) != 2;
            write_board_side(CFG_W'(side_val));

            for (int k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    a = STEP_W'($urandom_range(0, 31));
                    b = STEP_W'($urandom_range(0, 31));
                end
                else if (side_val >= MAX_SIDE_DEF)
                begin
                    // short steps on the big board explore most of it
                    a = STEP_W'($urandom_range(1, 4));
                    b = STEP_W'($urandom_range(0, 8));
                end
                else
                begin
                    a = STEP_W'($urandom_range(0, side_val - 1));
                    b = STEP_W'($urandom_range(0, side_val - 1));
                end
                send_leap(a, b);
            end
            drain_searches();
        end
        idle_gaps = 1'b1;
    endtask

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.step_a     = '0;
        req_ch.step_b     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.board_side = SIDE_RESET;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_board();
        test_side_extremes();
        test_zero_steps();
        test_tiny_boards();
        test_random_boards();

        // nothing outstanding now; give the block time to show any stray result
        drain_searches();
        repeat (50) @(negedge clk);
        if (pending_paths.size() != 0)
            report_failure($sformatf("%0d searches never returned a distance",
                                     pending_paths.size()));

        $display("searched %0d leaper step pairs over %0d board side settings (0 to 63)",
                 searches_sent, side_writes);
        $display("checked %0d distances in %0d cycles, %0d failures",
                 distances_checked, cycle_count, failures);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
